FILE: rtl/sigpk_pkg.sv
// ----------------------------------------------------------------------------
// sigpk_pkg
// Shared types and constants for the signal-to-PDU packer.
// ----------------------------------------------------------------------------
package sigpk_pkg;

  localparam int unsigned MSG_W   = 4;
  localparam int unsigned SID_W   = 6;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned START_W = 6;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned BIDX_W  = 3;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd64;

  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    F_CLEAR = 2'd0,
    F_IDLE  = 2'd1,
    F_LOOK  = 2'd2
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_RUN   = 2'd2
  } back_state_e;

  typedef struct packed {
    logic               valid;
    logic [MSG_W-1:0]   msg;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               big;
  } desc_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               status;
    logic [MSG_W-1:0]   msg;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic               big;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/sigpk_front.sv
// ----------------------------------------------------------------------------
// sigpk_front
// Accepts requests, keeps the signal descriptor table and turns each request
// into a command for the back end.
// ----------------------------------------------------------------------------
module sigpk_front #(
  parameter int unsigned SIGNALS  = 64,
  parameter int unsigned MESSAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [1:0]                           req_type_i,
  input  logic [sigpk_pkg::SID_W-1:0]          sig_num_i,
  input  logic [sigpk_pkg::VAL_W-1:0]          signal_value_i,
  input  logic [sigpk_pkg::MSG_W-1:0]          msg_num_i,
  input  logic [sigpk_pkg::START_W-1:0]        first_bit_i,
  input  logic [sigpk_pkg::SIZE_W-1:0]         bit_size_i,
  input  logic                                 big_endian_i,
  output logic                                 busy_o,
  input  sigpk_pkg::q_status_t                 q_status_i,
  output logic                                 push_o,
  output sigpk_pkg::cmd_t                      cmd_o
);
  import sigpk_pkg::*;

  localparam int unsigned SIW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;

  desc_t              tbl_mem [SIGNALS];
  desc_t              rd_desc_q;
  logic [VAL_W-1:0]   val_q;
  logic [SIW-1:0]     clr_q, clr_d;
  front_state_e       state_q, state_d;

  logic               accept;
  logic               sid_ok, msg_ok, desc_msg_ok;
  logic               tbl_we, tbl_re;
  logic [SIW-1:0]     tbl_addr;
  desc_t              tbl_wdata;
  cmd_t               err_cmd;

  assign busy_o      = (state_q != F_IDLE) | q_status_i.full;
  assign accept      = start_i & ~busy_o;
  assign sid_ok      = 32'(sig_num_i) < SIGNALS;
  assign msg_ok      = 32'(msg_num_i) < MESSAGES;
  assign desc_msg_ok = 32'(rd_desc_q.msg) < MESSAGES;

  always_comb begin
    err_cmd        = '0;
    err_cmd.kind   = CMD_STATUS;
    err_cmd.status = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      F_CLEAR: begin
        clr_d = clr_q + SIW'(1);
        if (clr_q == SIW'(SIGNALS - 1)) begin
          state_d = F_IDLE;
        end
      end
      F_IDLE: begin
        if (accept && req_type_i == REQ_WRITE && sid_ok) begin
          state_d = F_LOOK;
        end
      end
      F_LOOK:  state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    push_o          = 1'b0;
    cmd_o           = err_cmd;
    tbl_we          = 1'b0;
    tbl_re          = 1'b0;
    tbl_addr        = SIW'(sig_num_i);
    tbl_wdata       = '0;
    case (state_q)
      F_CLEAR: begin
        tbl_we   = 1'b1;
        tbl_addr = clr_q;
      end
      F_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_WRITE: begin
              if (sid_ok) begin
                tbl_re = 1'b1;
              end else begin
                push_o = 1'b1;
              end
            end
            REQ_READ: begin
              push_o = 1'b1;
              if (msg_ok) begin
                cmd_o.kind   = CMD_READ;
                cmd_o.status = 1'b0;
                cmd_o.msg    = msg_num_i;
              end
            end
            REQ_LOAD: begin
              push_o = 1'b1;
              if (sid_ok && msg_ok) begin
                tbl_we          = 1'b1;
                tbl_wdata.valid = 1'b1;
                tbl_wdata.msg   = msg_num_i;
                tbl_wdata.start = first_bit_i;
                tbl_wdata.size  = bit_size_i;
                tbl_wdata.big   = big_endian_i;
                cmd_o.status    = 1'b0;
                cmd_o.msg       = msg_num_i;
              end
            end
            default: push_o = 1'b1;
          endcase
        end
      end
      F_LOOK: begin
        push_o = 1'b1;
        if (rd_desc_q.valid && desc_msg_ok) begin
          cmd_o.kind   = CMD_WRITE;
          cmd_o.status = 1'b0;
          cmd_o.msg    = rd_desc_q.msg;
          cmd_o.start  = rd_desc_q.start;
          cmd_o.size   = rd_desc_q.size;
          cmd_o.big    = rd_desc_q.big;
          cmd_o.value  = val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (tbl_re) begin
      rd_desc_q <= tbl_mem[tbl_addr];
    end
    if (accept) begin
      val_q <= signal_value_i;
    end
  end

endmodule

FILE: rtl/sigpk_cmd_q.sv
// ----------------------------------------------------------------------------
// sigpk_cmd_q
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sigpk_cmd_q (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sigpk_pkg::cmd_t      cmd_i,
  input  logic                 pop_i,
  output sigpk_pkg::cmd_t      cmd_o,
  output sigpk_pkg::q_status_t status_o
);
  import sigpk_pkg::*;

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign status_o.full  = cnt_q == CW'(CMDQ_DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign cmd_o          = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/sigpk_back.sv
// ----------------------------------------------------------------------------
// sigpk_back
// Owns the message buffers: merges signal bits byte by byte, reads messages
// out and drives the result ports.
// ----------------------------------------------------------------------------
module sigpk_back #(
  parameter int unsigned MESSAGES  = 16,
  parameter int unsigned PDU_BYTES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sigpk_pkg::q_status_t                q_status_i,
  input  sigpk_pkg::cmd_t                     cmd_i,
  output logic                                pop_o,
  output logic                                result_valid_o,
  output logic                                status_o,
  output logic [sigpk_pkg::MSG_W-1:0]         out_message_o,
  output logic [sigpk_pkg::BIDX_W-1:0]        byte_index_o,
  output logic [sigpk_pkg::BYTE_W-1:0]        data_byte_o,
  output logic                                last_o
);
  import sigpk_pkg::*;

  localparam int unsigned DEPTH = MESSAGES * PDU_BYTES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW    = $clog2(PDU_BYTES + 1);
  localparam int unsigned IW    = (PDU_BYTES > 1) ? $clog2(PDU_BYTES) : 1;
  localparam int unsigned OW    = IW + 9;

  logic [BYTE_W-1:0] mem [DEPTH];

  back_state_e        state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  cmd_t               cmd_q, cmd_d;
  logic [KW-1:0]      rd_cnt_q, rd_cnt_d;
  logic               pend_q, pend_d;
  logic [IW-1:0]      pend_idx_q, pend_idx_d;
  logic [BYTE_W-1:0]  rd_data_q;
  logic               pend_last;

  logic               res_v_d, res_st_d, res_last_d;
  logic [MSG_W-1:0]   res_msg_d;
  logic [BIDX_W-1:0]  res_idx_d;
  logic [BYTE_W-1:0]  res_byte_d;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr, base;
  logic [BYTE_W-1:0]  mem_wdata, merged, bmask, bbits;

  logic [SIZE_W-1:0]        size_c;
  logic [START_W-1:0]       qs;
  logic signed [OW-1:0]     k8, off, bidx;

  assign pend_last = pend_idx_q == IW'(PDU_BYTES - 1);
  assign base      = AW'(32'(cmd_q.msg) * PDU_BYTES);

  // Work out which bits of the pending byte belong to the signal
  always_comb begin
    size_c = (cmd_q.size > SIZE_MAX) ? SIZE_MAX : cmd_q.size;
    qs     = {cmd_q.start[START_W-1:3], ~cmd_q.start[2:0]};
    k8     = OW'(signed'({1'b0, pend_idx_q, 3'b000}));
    if (cmd_q.big) begin
      off = OW'(signed'({1'b0, qs})) + OW'(signed'({1'b0, size_c})) - OW'(8) - k8;
    end else begin
      off = k8 - OW'(signed'({1'b0, cmd_q.start}));
    end
    bmask = '0;
    bbits = '0;
    bidx  = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      bidx     = off + OW'(j);
      bmask[j] = (bidx >= 0) && (bidx < OW'(signed'({1'b0, size_c})));
      bbits[j] = cmd_q.value[bidx[5:0]];
    end
    merged = (rd_data_q & ~bmask) | (bbits & bmask);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_status_i.empty && cmd_i.kind != CMD_STATUS) begin
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (pend_q && pend_last) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    rd_cnt_d   = rd_cnt_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = base + AW'(pend_idx_q);
    mem_wdata  = merged;
    mem_re     = 1'b0;
    mem_raddr  = base + AW'(rd_cnt_q);
    res_v_d    = 1'b0;
    res_st_d   = 1'b0;
    res_msg_d  = cmd_q.msg;
    res_idx_d  = '0;
    res_byte_d = '0;
    res_last_d = 1'b1;
    case (state_q)
      B_CLEAR: begin
        clr_d     = clr_q + AW'(1);
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          rd_cnt_d = '0;
          if (cmd_i.kind == CMD_STATUS) begin
            res_v_d   = 1'b1;
            res_st_d  = cmd_i.status;
            res_msg_d = cmd_i.msg;
          end
        end
      end
      B_RUN: begin
        if (rd_cnt_q < KW'(PDU_BYTES)) begin
          mem_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + KW'(1);
        end
        if (pend_q) begin
          if (cmd_q.kind == CMD_READ) begin
            res_v_d    = 1'b1;
            res_idx_d  = BIDX_W'(pend_idx_q);
            res_byte_d = rd_data_q;
            res_last_d = pend_last;
          end else begin
            mem_we  = 1'b1;
            res_v_d = pend_last;
          end
        end
      end
      default: ;
    endcase
    pend_d     = mem_re;
    pend_idx_d = IW'(rd_cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_CLEAR;
      clr_q          <= '0;
      rd_cnt_q       <= '0;
      pend_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      rd_cnt_q       <= rd_cnt_d;
      pend_q         <= pend_d;
      result_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    pend_idx_q    <= pend_idx_d;
    status_o      <= res_st_d;
    out_message_o <= res_msg_d;
    byte_index_o  <= res_idx_d;
    data_byte_o   <= res_byte_d;
    last_o        <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

endmodule

FILE: rtl/signal_to_pdu_packer_top.sv
// ----------------------------------------------------------------------------
// signal_to_pdu_packer_top
// Packs signal values into message buffers in Intel or Motorola bit order,
// keeps the signal descriptor table and reads messages out byte by byte.
//
//  channel   handshake             payload
//  request   start_i / busy_o      req_type_i .. big_endian_i
//  result    result_valid_o        status_o .. last_o (one cycle each)
//
// A load, error or unused-code request gives its result once the back end
// pops its command from the queue; a write first has its descriptor looked up.
// A mapped write gives its result once the back end has read and rewritten
// each byte of the message through the buffer memory's read and write ports.
// A read out gives PDU_BYTES results on consecutive cycles.
// After reset the buffers and the table are cleared entry by entry; requests
// queue up behind the buffer clear.
// busy_o is high while the table is being cleared, a descriptor is being
// looked up or the queue is full; results are never stalled.
// ----------------------------------------------------------------------------
module signal_to_pdu_packer_top #(
  parameter int unsigned MESSAGES  = 16,
  parameter int unsigned PDU_BYTES = 8,
  parameter int unsigned SIGNALS   = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          req_type_i,
  input  logic [sigpk_pkg::SID_W-1:0]         sig_num_i,
  input  logic [sigpk_pkg::VAL_W-1:0]         signal_value_i,
  input  logic [sigpk_pkg::MSG_W-1:0]         msg_num_i,
  input  logic [sigpk_pkg::START_W-1:0]       first_bit_i,
  input  logic [sigpk_pkg::SIZE_W-1:0]        bit_size_i,
  input  logic                                big_endian_i,
  output logic                                result_valid_o,
  output logic                                status_o,
  output logic [sigpk_pkg::MSG_W-1:0]         out_message_o,
  output logic [sigpk_pkg::BIDX_W-1:0]        byte_index_o,
  output logic [sigpk_pkg::BYTE_W-1:0]        data_byte_o,
  output logic                                last_o
);
  import sigpk_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd, head_cmd;
  logic      push, pop;

  sigpk_front #(
    .SIGNALS  (SIGNALS),
    .MESSAGES (MESSAGES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_type_i     (req_type_i),
    .sig_num_i      (sig_num_i),
    .signal_value_i (signal_value_i),
    .msg_num_i      (msg_num_i),
    .first_bit_i    (first_bit_i),
    .bit_size_i     (bit_size_i),
    .big_endian_i   (big_endian_i),
    .busy_o         (busy_o),
    .q_status_i     (q_status),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  sigpk_cmd_q u_cmd_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  sigpk_back #(
    .MESSAGES  (MESSAGES),
    .PDU_BYTES (PDU_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_message_o  (out_message_o),
    .byte_index_o   (byte_index_o),
    .data_byte_o    (data_byte_o),
    .last_o         (last_o)
  );

endmodule
